// File: sv/ffsa_pkg.sv
// Shared types, sizes and command codes for the first-fit segment allocator.
// Used by ffsa_ctrl, ffsa_dp and the top level; depends on nothing.
`default_nettype none
package ffsa_pkg;

    localparam int CAPACITY     = 2048;
    localparam int MAX_SEGMENTS = 64;

    localparam int START_W = $clog2(CAPACITY);
    localparam int SIZE_W  = START_W + 1;
    localparam int IDX_W   = $clog2(MAX_SEGMENTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int REQ_W   = 12;
    localparam int ADDR_W  = 11;
    localparam int TAG_W   = 8;
    localparam int STAT_W  = 2;
    localparam int SUM_W   = ((SIZE_W > REQ_W) ? SIZE_W : REQ_W) + 1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_OWNER   = 2'd2;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 2'd3;

    localparam logic [4:0] CMD_NONE         = 5'd0;
    localparam logic [4:0] CMD_ACCEPT       = 5'd1;
    localparam logic [4:0] CMD_READ         = 5'd2;
    localparam logic [4:0] CMD_SCAN_NEXT    = 5'd3;
    localparam logic [4:0] CMD_CAPTURE      = 5'd4;
    localparam logic [4:0] CMD_SHUP_READ    = 5'd5;
    localparam logic [4:0] CMD_SHUP_WRITE   = 5'd6;
    localparam logic [4:0] CMD_SPLIT        = 5'd7;
    localparam logic [4:0] CMD_ALLOC        = 5'd8;
    localparam logic [4:0] CMD_READ_NEXT    = 5'd9;
    localparam logic [4:0] CMD_CAPTURE_NEXT = 5'd10;
    localparam logic [4:0] CMD_REL_SET      = 5'd11;
    localparam logic [4:0] CMD_SHDN_READ    = 5'd12;
    localparam logic [4:0] CMD_SHDN_WRITE   = 5'd13;
    localparam logic [4:0] CMD_REL_DONE     = 5'd14;
    localparam logic [4:0] CMD_FAIL         = 5'd15;
    localparam logic [4:0] CMD_EMIT         = 5'd16;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
        logic               used;
        logic [TAG_W-1:0]   owner;
    } entry_t;

    typedef struct packed {
        logic [4:0]        code;
        logic [STAT_W-1:0] fail_status;
    } cmd_t;

    typedef struct packed {
        logic is_release;
        logic pre_fail;
        logic at_end;
        logic fit;
        logic exact;
        logic full;
        logic match;
        logic has_next;
        logic up_more;
        logic dn_more;
        logic out_free;
    } dp_status_t;

    function automatic entry_t reset_entry();
        entry_t e;
        e.start = '0;
        e.size  = SIZE_W'(CAPACITY);
        e.used  = 1'b0;
        e.owner = '0;
        return e;
    endfunction

endpackage
`default_nettype wire

// File: sv/ffsa_ctrl.sv
// Sequencer for the allocator: walks scan, shift and merge steps.
// Depends on ffsa_pkg; drives ffsa_dp through cmd_t and reads dp_status_t.
`default_nettype none
module ffsa_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ffsa_pkg::dp_status_t st,
    output ffsa_pkg::cmd_t           cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PRE   = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_EV    = 4'd3;
    localparam logic [3:0] S_UPCHK = 4'd4;
    localparam logic [3:0] S_UPWR  = 4'd5;
    localparam logic [3:0] S_SPL   = 4'd6;
    localparam logic [3:0] S_AEX   = 4'd7;
    localparam logic [3:0] S_RDN   = 4'd8;
    localparam logic [3:0] S_CAPN  = 4'd9;
    localparam logic [3:0] S_REL   = 4'd10;
    localparam logic [3:0] S_DNCHK = 4'd11;
    localparam logic [3:0] S_DNWR  = 4'd12;
    localparam logic [3:0] S_EMIT  = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        cmd.code         = ffsa_pkg::CMD_NONE;
        cmd.fail_status  = ffsa_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.code   = ffsa_pkg::CMD_ACCEPT;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                if (!st.is_release && st.pre_fail)
                begin
                    cmd.code        = ffsa_pkg::CMD_FAIL;
                    cmd.fail_status = ffsa_pkg::ST_NO_SPACE;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (st.at_end)
                begin
                    cmd.code        = ffsa_pkg::CMD_FAIL;
                    cmd.fail_status = st.is_release ? ffsa_pkg::ST_NO_OWNER
                                                    : ffsa_pkg::ST_NO_SPACE;
                    state_next      = S_EMIT;
                end
                else
                begin
                    cmd.code   = ffsa_pkg::CMD_READ;
                    state_next = S_EV;
                end
            end
            S_EV:
            begin
                if (!st.is_release && st.fit)
                begin
                    if (st.exact)
                    begin
                        cmd.code   = ffsa_pkg::CMD_CAPTURE;
                        state_next = S_AEX;
                    end
                    else if (st.full)
                    begin
                        cmd.code        = ffsa_pkg::CMD_FAIL;
                        cmd.fail_status = ffsa_pkg::ST_TABLE_FULL;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        cmd.code   = ffsa_pkg::CMD_CAPTURE;
                        state_next = S_UPCHK;
                    end
                end
                else if (st.is_release && st.match)
                begin
                    cmd.code   = ffsa_pkg::CMD_CAPTURE;
                    state_next = st.has_next ? S_RDN : S_REL;
                end
                else
                begin
                    cmd.code   = ffsa_pkg::CMD_SCAN_NEXT;
                    state_next = S_RD;
                end
            end
            S_UPCHK:
            begin
                if (st.up_more)
                begin
                    cmd.code   = ffsa_pkg::CMD_SHUP_READ;
                    state_next = S_UPWR;
                end
                else
                begin
                    state_next = S_SPL;
                end
            end
            S_UPWR:
            begin
                cmd.code   = ffsa_pkg::CMD_SHUP_WRITE;
                state_next = S_UPCHK;
            end
            S_SPL:
            begin
                cmd.code   = ffsa_pkg::CMD_SPLIT;
                state_next = S_AEX;
            end
            S_AEX:
            begin
                cmd.code   = ffsa_pkg::CMD_ALLOC;
                state_next = S_EMIT;
            end
            S_RDN:
            begin
                cmd.code   = ffsa_pkg::CMD_READ_NEXT;
                state_next = S_CAPN;
            end
            S_CAPN:
            begin
                cmd.code   = ffsa_pkg::CMD_CAPTURE_NEXT;
                state_next = S_REL;
            end
            S_REL:
            begin
                cmd.code   = ffsa_pkg::CMD_REL_SET;
                state_next = S_DNCHK;
            end
            S_DNCHK:
            begin
                if (st.dn_more)
                begin
                    cmd.code   = ffsa_pkg::CMD_SHDN_READ;
                    state_next = S_DNWR;
                end
                else
                begin
                    cmd.code   = ffsa_pkg::CMD_REL_DONE;
                    state_next = S_EMIT;
                end
            end
            S_DNWR:
            begin
                cmd.code   = ffsa_pkg::CMD_SHDN_WRITE;
                state_next = S_DNCHK;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.code   = ffsa_pkg::CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// File: sv/ffsa_dp.sv
// Datapath of the allocator: segment table memory, counters and result register.
// Depends on ffsa_pkg; sequenced by ffsa_ctrl.
`default_nettype none
module ffsa_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ffsa_pkg::cmd_t               cmd,
    output ffsa_pkg::dp_status_t              st,
    input  wire logic                         opcode,
    input  wire logic [ffsa_pkg::REQ_W-1:0]   block_size,
    input  wire logic [ffsa_pkg::TAG_W-1:0]   owner_tag,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [ffsa_pkg::STAT_W-1:0]       status,
    output logic [ffsa_pkg::ADDR_W-1:0]       address
);

    localparam int IW = ffsa_pkg::IDX_W;
    localparam int CW = ffsa_pkg::CNT_W;
    localparam int SW = ffsa_pkg::SUM_W;

    ffsa_pkg::entry_t mem [ffsa_pkg::MAX_SEGMENTS];
    ffsa_pkg::entry_t mem_q;
    ffsa_pkg::entry_t rd_entry;
    ffsa_pkg::entry_t cur_reg;
    ffsa_pkg::entry_t prev_reg;
    ffsa_pkg::entry_t wdata;

    logic                           mem_we;
    logic                           mem_re;
    logic [IW-1:0]                  waddr;
    logic [IW-1:0]                  raddr;

    logic                           op_reg;
    logic [ffsa_pkg::REQ_W-1:0]     req_reg;
    logic [ffsa_pkg::TAG_W-1:0]     tag_reg;
    logic [CW-1:0]                  idx_reg;
    logic [CW-1:0]                  cnt_reg;
    logic [CW-1:0]                  k_reg;
    logic [1:0]                     d_reg;
    logic [ffsa_pkg::SIZE_W-1:0]    used_reg;
    logic                           prev_free_reg;
    logic                           nxt_free_reg;
    logic [ffsa_pkg::SIZE_W-1:0]    nxt_size_reg;
    logic                           init_done_reg;
    logic                           rd_zero_reg;
    logic                           rd_zero_next;
    logic                           out_valid_reg;
    logic [ffsa_pkg::STAT_W-1:0]    pend_status_reg;
    logic [ffsa_pkg::START_W-1:0]   pend_addr_reg;
    logic [ffsa_pkg::STAT_W-1:0]    status_reg;
    logic [ffsa_pkg::START_W-1:0]   address_reg;

    logic [SW-1:0]                  req_ext;
    logic [SW-1:0]                  rd_size_ext;
    logic [ffsa_pkg::SIZE_W-1:0]    req_size;
    logic [ffsa_pkg::SIZE_W-1:0]    merge_size;
    logic [CW-1:0]                  idx_inc;
    logic [CW-1:0]                  idx_dec;
    logic [CW:0]                    k_plus_d;

    assign req_ext     = SW'(req_reg);
    assign rd_size_ext = SW'(rd_entry.size);
    assign req_size    = ffsa_pkg::SIZE_W'(req_reg);
    assign idx_inc     = idx_reg + CW'(1);
    assign idx_dec     = idx_reg - CW'(1);
    assign k_plus_d    = (CW+1)'(k_reg) + (CW+1)'(d_reg);

    // Entry zero reads as the whole free capacity until it is first written.
    assign rd_entry = rd_zero_reg ? ffsa_pkg::reset_entry() : mem_q;

    assign merge_size = cur_reg.size
                      + (nxt_free_reg ? nxt_size_reg : '0)
                      + (prev_free_reg ? prev_reg.size : '0);

    assign st.is_release = (op_reg == ffsa_pkg::OP_RELEASE);
    assign st.pre_fail   = (req_reg == '0)
                         || ((SW'(used_reg) + req_ext) > SW'(ffsa_pkg::CAPACITY));
    assign st.at_end     = (idx_reg == cnt_reg);
    assign st.fit        = !rd_entry.used && (rd_size_ext >= req_ext);
    assign st.exact      = (rd_size_ext == req_ext);
    assign st.full       = (cnt_reg == CW'(ffsa_pkg::MAX_SEGMENTS));
    assign st.match      = rd_entry.used && (rd_entry.owner == tag_reg);
    assign st.has_next   = (idx_inc < cnt_reg);
    assign st.up_more    = (k_reg > idx_inc);
    assign st.dn_more    = (d_reg != 2'd0) && (k_plus_d < (CW+1)'(cnt_reg));
    assign st.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        waddr  = idx_reg[IW-1:0];
        raddr  = idx_reg[IW-1:0];
        wdata  = rd_entry;
        case (cmd.code)
            ffsa_pkg::CMD_READ:
            begin
                mem_re = 1'b1;
            end
            ffsa_pkg::CMD_SHUP_READ:
            begin
                mem_re = 1'b1;
                raddr  = IW'(k_reg - CW'(1));
            end
            ffsa_pkg::CMD_SHUP_WRITE:
            begin
                mem_we = 1'b1;
                waddr  = k_reg[IW-1:0];
            end
            ffsa_pkg::CMD_SPLIT:
            begin
                mem_we      = 1'b1;
                waddr       = idx_inc[IW-1:0];
                wdata.start = cur_reg.start + ffsa_pkg::START_W'(req_reg);
                wdata.size  = cur_reg.size - req_size;
                wdata.used  = 1'b0;
                wdata.owner = '0;
            end
            ffsa_pkg::CMD_ALLOC:
            begin
                mem_we      = 1'b1;
                wdata.start = cur_reg.start;
                wdata.size  = req_size;
                wdata.used  = 1'b1;
                wdata.owner = tag_reg;
            end
            ffsa_pkg::CMD_READ_NEXT:
            begin
                mem_re = 1'b1;
                raddr  = idx_inc[IW-1:0];
            end
            ffsa_pkg::CMD_REL_SET:
            begin
                mem_we      = 1'b1;
                waddr       = prev_free_reg ? idx_dec[IW-1:0] : idx_reg[IW-1:0];
                wdata.start = prev_free_reg ? prev_reg.start : cur_reg.start;
                wdata.size  = merge_size;
                wdata.used  = 1'b0;
                wdata.owner = '0;
            end
            ffsa_pkg::CMD_SHDN_READ:
            begin
                mem_re = 1'b1;
                raddr  = k_plus_d[IW-1:0];
            end
            ffsa_pkg::CMD_SHDN_WRITE:
            begin
                mem_we = 1'b1;
                waddr  = k_reg[IW-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign rd_zero_next = (raddr == '0) && !init_done_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (mem_re)
            mem_q <= mem[raddr];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (cmd.code)
            ffsa_pkg::CMD_ACCEPT:
            begin
                op_reg  <= opcode;
                req_reg <= block_size;
                tag_reg <= owner_tag;
            end
            ffsa_pkg::CMD_SCAN_NEXT:
            begin
                prev_reg <= rd_entry;
            end
            ffsa_pkg::CMD_CAPTURE:
            begin
                cur_reg <= rd_entry;
            end
            ffsa_pkg::CMD_CAPTURE_NEXT:
            begin
                nxt_size_reg <= rd_entry.size;
            end
            ffsa_pkg::CMD_ALLOC:
            begin
                pend_status_reg <= ffsa_pkg::ST_OK;
                pend_addr_reg   <= cur_reg.start;
            end
            ffsa_pkg::CMD_REL_DONE:
            begin
                pend_status_reg <= ffsa_pkg::ST_OK;
                pend_addr_reg   <= '0;
            end
            ffsa_pkg::CMD_FAIL:
            begin
                pend_status_reg <= cmd.fail_status;
                pend_addr_reg   <= '0;
            end
            ffsa_pkg::CMD_EMIT:
            begin
                status_reg  <= pend_status_reg;
                address_reg <= pend_addr_reg;
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= CW'(1);
            k_reg         <= '0;
            d_reg         <= '0;
            used_reg      <= '0;
            prev_free_reg <= 1'b0;
            nxt_free_reg  <= 1'b0;
            init_done_reg <= 1'b0;
            rd_zero_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_re)
                rd_zero_reg <= rd_zero_next;
            if (mem_we && (waddr == '0))
                init_done_reg <= 1'b1;
            if (cmd.code == ffsa_pkg::CMD_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (cmd.code)
                ffsa_pkg::CMD_ACCEPT:
                begin
                    idx_reg       <= '0;
                    prev_free_reg <= 1'b0;
                end
                ffsa_pkg::CMD_SCAN_NEXT:
                begin
                    idx_reg       <= idx_inc;
                    prev_free_reg <= !rd_entry.used;
                end
                ffsa_pkg::CMD_CAPTURE:
                begin
                    k_reg        <= cnt_reg;
                    nxt_free_reg <= 1'b0;
                end
                ffsa_pkg::CMD_SHUP_WRITE:
                begin
                    k_reg <= k_reg - CW'(1);
                end
                ffsa_pkg::CMD_SPLIT:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                ffsa_pkg::CMD_ALLOC:
                begin
                    used_reg <= used_reg + req_size;
                end
                ffsa_pkg::CMD_CAPTURE_NEXT:
                begin
                    nxt_free_reg <= !rd_entry.used;
                end
                ffsa_pkg::CMD_REL_SET:
                begin
                    used_reg <= used_reg - cur_reg.size;
                    k_reg    <= prev_free_reg ? idx_reg : idx_inc;
                    d_reg    <= {1'b0, prev_free_reg} + {1'b0, nxt_free_reg};
                end
                ffsa_pkg::CMD_SHDN_WRITE:
                begin
                    k_reg <= k_reg + CW'(1);
                end
                ffsa_pkg::CMD_REL_DONE:
                begin
                    cnt_reg <= cnt_reg - CW'(d_reg);
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign address   = ffsa_pkg::ADDR_W'(address_reg);

endmodule
`default_nettype wire

// File: sv/first_fit_segment_allocator_core.sv
// First-fit segment allocator over an address-ordered segment table.
// An input word is an allocate (opcode 0, block_size, owner_tag) or a release
// (opcode 1, owner_tag) request; each request yields exactly one output word
// with status and address. Both channels use valid and stall: a word moves
// on a rising edge with valid high and stall low.
// Requests are handled one at a time. The table lives in a single-port-read
// memory and each entry visited is read, then evaluated; when a split or
// merge shifts the table tail, each entry moved is read, then written. The
// table holds at most 64 entries.
// The result sits in an output register, so the next request is taken while
// an earlier word still waits; if the receiver stalls, a finished request
// holds until the register frees up.
// After reset the memory is one free segment covering the whole capacity;
// no clearing pass is needed and requests are accepted right away.
// Depends on ffsa_pkg, ffsa_ctrl and ffsa_dp.
`default_nettype none
module first_fit_segment_allocator_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         opcode,
    input  wire logic [ffsa_pkg::REQ_W-1:0]   block_size,
    input  wire logic [ffsa_pkg::TAG_W-1:0]   owner_tag,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [ffsa_pkg::STAT_W-1:0]       status,
    output logic [ffsa_pkg::ADDR_W-1:0]       address
);

    ffsa_pkg::cmd_t       cmd;
    ffsa_pkg::dp_status_t st;

    ffsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    ffsa_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .opcode     (opcode),
        .block_size (block_size),
        .owner_tag  (owner_tag),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .address    (address)
    );

endmodule
`default_nettype wire
